[rtl/rrd_pkg.sv]
// Shared types and constants for the run-length run decoder.
// Used by the front end, the queue, the back end, the top level and the checker.
package rrd_pkg;

	// Frame header: original length, least significant byte first.
	localparam int HDR_BYTES = 8;
	localparam int HDR_IDX_W = $clog2(HDR_BYTES + 1);
	localparam int LEN_W     = 8 * HDR_BYTES;

	// Depth of the queue between front end and back end.
	localparam int Q_DEPTH = 2;
	localparam int Q_IDX_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// What the back end has to do with one queued entry.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_HDR,
		OP_PAIR
	} op_kind_t;

	// Frame status reported with the final beat.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_ZERO     = 2'd2,
		ST_MISMATCH = 2'd3
	} status_t;

	// One classified beat, handed from the front end to the back end.
	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;      // header byte or run value
		logic [7:0] count;     // run count of a complete pair
		logic       last;      // final beat of the frame
		logic       short_hdr; // header still incomplete after this beat
	} op_t;

	// Queue push and pop handshakes.
	typedef struct packed {
		logic valid;
		op_t  op;
	} q_push_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} q_head_t;

endpackage

[rtl/rrd_if.sv]
// Stream interfaces of the run-length run decoder: compressed input bytes
// and decoded result items. Depends on nothing but the language.
interface rrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface rrd_out_if;
	logic       valid;
	logic       ready;
	logic       run_valid;
	logic [7:0] run_value;
	logic [7:0] run_length;
	logic       frame_done;
	logic [1:0] status;

	modport source (output valid, output run_valid, output run_value, output run_length,
		output frame_done, output status, input ready);
	modport sink   (input valid, input run_valid, input run_value, input run_length,
		input frame_done, input status, output ready);
endinterface

[rtl/rrd_front.sv]
// Front end: takes compressed beats, counts off the header and pairs
// count and value bytes into queue entries. Depends on rrd_pkg.
module rrd_front import rrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_data,
	input  logic       in_last,
	input  logic       q_full,
	output logic       in_ready,
	output q_push_t    push
);

	logic [HDR_IDX_W-1:0] hdr_idx_q;
	logic                 expect_q;
	logic [7:0]           count_q;
	logic                 accept;
	logic                 in_hdr;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign in_hdr   = hdr_idx_q < HDR_IDX_W'(HDR_BYTES);

	// Classify the beat and decide whether it needs the back end.
	always_comb begin
		push.valid        = 1'b0;
		push.op.kind      = OP_NONE;
		push.op.data      = in_data;
		push.op.count     = count_q;
		push.op.last      = in_last;
		push.op.short_hdr = 1'b0;
		if (in_hdr) begin
			push.valid        = accept;
			push.op.kind      = OP_HDR;
			push.op.short_hdr = hdr_idx_q != HDR_IDX_W'(HDR_BYTES - 1);
		end else if (!expect_q) begin
			// A lone count byte only matters when it ends the frame.
			push.valid = accept && in_last;
		end else begin
			push.valid   = accept;
			push.op.kind = OP_PAIR;
		end
	end

	// Header position and pair phase; a final beat starts a new frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q <= '0;
			expect_q  <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				hdr_idx_q <= '0;
				expect_q  <= 1'b0;
			end else if (in_hdr) begin
				hdr_idx_q <= hdr_idx_q + HDR_IDX_W'(1);
			end else begin
				expect_q <= !expect_q;
			end
		end
	end

	// Held count byte of the pair in progress.
	always_ff @(posedge clk) begin
		if (accept && !in_hdr && !expect_q) begin
			count_q <= in_data;
		end
	end

endmodule

[rtl/rrd_queue.sv]
// Short queue between front end and back end, so that each side stalls
// on its own. Depends on rrd_pkg.
module rrd_queue import rrd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_push_t push,
	input  logic    pop,
	output logic    full,
	output q_head_t head
);

	op_t                mem_q [Q_DEPTH];
	logic [Q_IDX_W-1:0] wr_ptr_q;
	logic [Q_IDX_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_pop;

	assign full       = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.op    = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_IDX_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_IDX_W'(1);
			end
			if (push.valid && !do_pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (!push.valid && do_pop) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

endmodule

[rtl/rrd_back.sv]
// Back end: tracks the bytes still owed, clips runs, records a zero count
// and builds result beats in an output register. Depends on rrd_pkg.
module rrd_back import rrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_head_t    head,
	output logic       pop,
	input  logic       out_ready,
	output logic       out_valid,
	output logic       out_run_valid,
	output logic [7:0] out_run_value,
	output logic [7:0] out_run_length,
	output logic       out_frame_done,
	output status_t    out_status
);

	logic [LEN_W-1:0] rem_q;
	logic             stopped_q;
	logic             out_valid_q;
	logic             run_valid_q;
	logic [7:0]       run_value_q;
	logic [7:0]       run_length_q;
	logic             frame_done_q;
	status_t          status_q;

	logic             active;
	logic             zero_cnt;
	logic             emit;
	logic             fits;
	logic [7:0]       run_len;
	logic [LEN_W-1:0] rem_nx;
	logic             produce;
	status_t          status_nx;

	// An entry is taken whenever the output register is free or draining.
	assign pop = head.valid && (!out_valid_q || out_ready);

	// Pair handling: ignored once the length is reached or after a zero count.
	always_comb begin
		active   = (head.op.kind == OP_PAIR) && !stopped_q && (rem_q != '0);
		zero_cnt = active && (head.op.count == 8'd0);
		emit     = active && (head.op.count != 8'd0);
		fits     = (rem_q[LEN_W-1:8] != '0) || (rem_q[7:0] >= head.op.count);
		run_len  = fits ? head.op.count : rem_q[7:0];
		unique case (head.op.kind)
			OP_HDR:  rem_nx = {head.op.data, rem_q[LEN_W-1:8]};
			OP_PAIR: rem_nx = emit ? rem_q - LEN_W'(run_len) : rem_q;
			default: rem_nx = rem_q;
		endcase
		produce = emit || head.op.last;
	end

	// Final status, in order of precedence.
	always_comb begin
		priority if (head.op.short_hdr) begin
			status_nx = ST_SHORT;
		end else if (stopped_q || zero_cnt) begin
			status_nx = ST_ZERO;
		end else if (rem_nx != '0) begin
			status_nx = ST_MISMATCH;
		end else begin
			status_nx = ST_OK;
		end
	end

	// Decoder state; a final beat returns it to its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			stopped_q <= 1'b0;
		end else if (pop) begin
			if (head.op.last) begin
				rem_q     <= '0;
				stopped_q <= 1'b0;
			end else begin
				rem_q     <= rem_nx;
				stopped_q <= stopped_q || zero_cnt;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= produce;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop && produce) begin
			run_valid_q  <= emit;
			run_value_q  <= emit ? head.op.data : 8'd0;
			run_length_q <= emit ? run_len : 8'd0;
			frame_done_q <= head.op.last;
			status_q     <= head.op.last ? status_nx : ST_OK;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_run_valid  = run_valid_q;
	assign out_run_value  = run_value_q;
	assign out_run_length = run_length_q;
	assign out_frame_done = frame_done_q;
	assign out_status     = status_q;

endmodule

[rtl/rle_run_decoder_core.sv]
// Top level of the run-length run decoder: front end, queue and back end.
// Depends on rrd_pkg, rrd_if, rrd_front, rrd_queue and rrd_back.
//
// The decoder takes one compressed byte per cycle on frame while the queue
// is not full and returns at most one result beat per byte on result: a run
// (value and clipped length) and, on the final byte, the frame status. A
// byte passes through a queue entry into the back end's output register;
// the block keeps taking a byte every cycle while results are taken every
// cycle. The two-entry queue between the pairing front end and the back
// end absorbs a short stall, and the back end's 64-bit remaining-length
// subtract and compare, done once per pair, sets the cycle time.
module rle_run_decoder_core import rrd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	rrd_in_if.sink    frame,
	rrd_out_if.source result
);

	q_push_t push;
	q_head_t head;
	logic    q_full;
	logic    pop;
	status_t status;

	rrd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame.valid),
		.in_data  (frame.data_byte),
		.in_last  (frame.last),
		.q_full   (q_full),
		.in_ready (frame.ready),
		.push     (push)
	);

	rrd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	rrd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.out_run_valid  (result.run_valid),
		.out_run_value  (result.run_value),
		.out_run_length (result.run_length),
		.out_frame_done (result.frame_done),
		.out_status     (status)
	);

	assign result.status = status;

endmodule

[rtl/rrd_checker.sv]
// Port-level checks on the result stream of the run-length run decoder.
// Depends on rrd_pkg; bound to rle_run_decoder_core.
module rrd_checker import rrd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic       run_valid,
	input logic [7:0] run_value,
	input logic [7:0] run_length,
	input logic       frame_done,
	input logic [1:0] status
);

	// A stalled result beat keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(run_valid) && $stable(run_value)
			&& $stable(run_length) && $stable(frame_done) && $stable(status))
		else $error("result beat changed while stalled");

	// Every result beat carries a run, a frame end, or both.
	a_useful: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> run_valid || frame_done)
		else $error("empty result beat");

	// A run is never empty after clipping.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid && run_valid |-> run_length != 8'd0)
		else $error("run of zero length");

	// Without a run, value and length read as zero.
	a_norun: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !run_valid |-> run_value == 8'd0 && run_length == 8'd0)
		else $error("run fields set without a run");

	// Status is only reported on the frame's final beat.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !frame_done |-> status == ST_OK)
		else $error("status set before frame end");

endmodule

bind rle_run_decoder_core rrd_checker u_rrd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (result.valid),
	.ready      (result.ready),
	.run_valid  (result.run_valid),
	.run_value  (result.run_value),
	.run_length (result.run_length),
	.frame_done (result.frame_done),
	.status     (result.status)
);
